FILE: hdl/atcp_pkg.sv
// Shared types and constants of the AT command frame parser.
`default_nettype none
package atcp_pkg;

   localparam int NAME_MAX_DEFAULT    = 16;
   localparam int PAYLOAD_MAX_DEFAULT = 256;

   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_TIMEOUT = 1'b1;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_UPPER_T = 8'h54;
   localparam logic [7:0] CHAR_LOWER_T = 8'h74;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;

   localparam int MIN_FRAME_BYTES = 2;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_A    = 3'd1,
      PH_AT   = 3'd2,
      PH_ATCR = 3'd3,
      PH_NAME = 3'd4,
      PH_DATA = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      EV_OK        = 3'd0,
      EV_LETTER    = 3'd1,
      EV_DATA      = 3'd2,
      EV_VALID     = 3'd3,
      EV_MALFORMED = 3'd4,
      EV_ABORT     = 3'd5
   } event_type;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      event_type  event_res;
      logic [7:0] value;
      logic [4:0] name_count;
      logic [8:0] payload_count;
   } rsp_type;

   // Handshake state between the stages.
   typedef struct packed {
      logic fire;
      logic rsp_ready;
   } flow_type;

endpackage
`default_nettype wire

FILE: hdl/atcp_req_stage.sv
// Input register of the parser: holds one accepted beat until the parser takes it.
`default_nettype none
module atcp_req_stage
   import atcp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_ready,
   output      flow_type flow,
   output      req_type item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   always_comb begin
      flow.rsp_ready = rsp_ready;
      flow.fire      = valid_ff && rsp_ready;
      req_stall      = valid_ff && !rsp_ready;
      valid_in       = req_stall ? valid_ff : req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (!req_stall) begin
         item_ff <= req_data;
      end
   end

   assign item = item_ff;

endmodule
`default_nettype wire

FILE: hdl/atcp_parser.sv
// Parse state of the AT frame parser and the step logic for one beat.
`default_nettype none
module atcp_parser
   import atcp_pkg::*;
#(
   parameter int NAME_MAX    = NAME_MAX_DEFAULT,
   parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire flow_type flow,
   input  wire req_type  item,
   output      logic     res_valid,
   output      rsp_type  res
);

   localparam int LW  = $clog2(NAME_MAX + 1);
   localparam int BW  = $clog2(PAYLOAD_MAX + 1);
   localparam int LWX = (LW > 5) ? LW : 5;
   localparam int BWX = (BW > 9) ? BW : 9;

   phase_type      phase_ff, phase_in;
   logic [LW-1:0]  letters_ff, letters_in;
   logic [BW-1:0]  bytes_ff, bytes_in;
   logic [15:0]    last_ff, last_in;

   logic [7:0]     c;
   logic           is_a, is_t, is_letter, name_full, data_full, frame_ok;
   phase_type      look_a_phase;
   logic [LW-1:0]  emit_letters;
   logic [BW-1:0]  emit_bytes;
   logic [LWX-1:0] letters_wide;
   logic [BWX-1:0] bytes_wide;

   always_comb begin
      c            = item.rx_byte;
      is_a         = (c == CHAR_UPPER_A) || (c == CHAR_LOWER_A);
      is_t         = (c == CHAR_UPPER_T) || (c == CHAR_LOWER_T);
      is_letter    = ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
                     ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
      name_full    = letters_ff >= LW'(NAME_MAX);
      data_full    = bytes_ff >= BW'(PAYLOAD_MAX);
      frame_ok     = (bytes_ff >= BW'(MIN_FRAME_BYTES)) && (last_ff == {CHAR_CR, CHAR_LF});
      look_a_phase = is_a ? PH_A : PH_IDLE;
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (flow.fire) begin
         if (item.command == CMD_TIMEOUT) begin
            phase_in = PH_IDLE;
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  phase_in = look_a_phase;
               end
               PH_A: begin
                  phase_in = is_t ? PH_AT : look_a_phase;
               end
               PH_AT: begin
                  if (c == CHAR_PLUS) begin
                     phase_in = PH_NAME;
                  end else if (c == CHAR_CR) begin
                     phase_in = PH_ATCR;
                  end else begin
                     phase_in = look_a_phase;
                  end
               end
               PH_ATCR: begin
                  phase_in = (c == CHAR_LF) ? PH_IDLE : look_a_phase;
               end
               PH_NAME: begin
                  if (name_full) begin
                     phase_in = look_a_phase;
                  end else if (is_letter) begin
                     phase_in = PH_NAME;
                  end else begin
                     phase_in = data_full ? look_a_phase : PH_DATA;
                  end
               end
               PH_DATA: begin
                  phase_in = data_full ? look_a_phase : PH_DATA;
               end
               default: begin
                  // Unused phase codes behave as idle.
                  phase_in = look_a_phase;
               end
            endcase
         end
      end
   end

   // Counters, byte history and result.
   always_comb begin
      letters_in    = letters_ff;
      bytes_in      = bytes_ff;
      last_in       = last_ff;
      res_valid     = 1'b0;
      res.event_res = EV_OK;
      res.value     = 8'h00;
      emit_letters  = letters_ff;
      emit_bytes    = bytes_ff;
      if (flow.fire) begin
         if (item.command == CMD_TIMEOUT) begin
            if (phase_ff != PH_IDLE) begin
               res_valid     = 1'b1;
               res.event_res = frame_ok ? EV_VALID : EV_MALFORMED;
               letters_in    = '0;
               bytes_in      = '0;
               last_in       = '0;
            end
         end else begin
            case (phase_ff)
               PH_AT: begin
                  if (c == CHAR_PLUS) begin
                     letters_in = '0;
                     bytes_in   = '0;
                     last_in    = '0;
                  end
               end
               PH_ATCR: begin
                  if (c == CHAR_LF) begin
                     letters_in    = '0;
                     bytes_in      = '0;
                     last_in       = '0;
                     res_valid     = 1'b1;
                     res.event_res = EV_OK;
                     emit_letters  = '0;
                     emit_bytes    = '0;
                  end
               end
               PH_NAME, PH_DATA: begin
                  res_valid = 1'b1;
                  if ((phase_ff == PH_NAME && name_full) ||
                      ((phase_ff == PH_DATA || !is_letter) && data_full)) begin
                     res.event_res = EV_ABORT;
                     letters_in    = '0;
                     bytes_in      = '0;
                     last_in       = '0;
                  end else if (phase_ff == PH_NAME && is_letter) begin
                     letters_in    = letters_ff + LW'(1);
                     emit_letters  = letters_in;
                     res.event_res = EV_LETTER;
                     res.value     = c;
                  end else begin
                     bytes_in      = bytes_ff + BW'(1);
                     emit_bytes    = bytes_in;
                     last_in       = {last_ff[7:0], c};
                     res.event_res = EV_DATA;
                     res.value     = c;
                  end
               end
               default: begin
               end
            endcase
         end
      end
      letters_wide      = LWX'(emit_letters);
      bytes_wide        = BWX'(emit_bytes);
      res.name_count    = letters_wide[4:0];
      res.payload_count = bytes_wide[8:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         letters_ff <= '0;
         bytes_ff   <= '0;
         last_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         letters_ff <= letters_in;
         bytes_ff   <= bytes_in;
         last_ff    <= last_in;
      end
   end

   // Every byte in the name or data phase yields exactly one result.
   assert property (@(posedge clock) disable iff (reset)
      flow.fire && item.command == CMD_BYTE &&
      (phase_ff == PH_NAME || phase_ff == PH_DATA) |-> res_valid)
      else $error("name or data byte produced no result");

   // A timeout always leaves the parser idle with a cleared frame.
   assert property (@(posedge clock) disable iff (reset)
      flow.fire && item.command == CMD_TIMEOUT |=>
      phase_ff == PH_IDLE && letters_ff == '0 && bytes_ff == '0)
      else $error("timeout did not clear the frame");

   // The counters never pass their limits.
   assert property (@(posedge clock) disable iff (reset)
      letters_ff <= LW'(NAME_MAX) && bytes_ff <= BW'(PAYLOAD_MAX))
      else $error("frame counter beyond its limit");

   // State only moves when a beat is taken.
   assert property (@(posedge clock) disable iff (reset)
      !flow.fire |=> $stable(phase_ff) && $stable(bytes_ff) && $stable(letters_ff))
      else $error("parse state changed without a beat");

endmodule
`default_nettype wire

FILE: hdl/atcp_rsp_stage.sv
// Result register of the parser, held while the receiver stalls.
`default_nettype none
module atcp_rsp_stage
   import atcp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire flow_type flow,
   input  wire logic     res_valid,
   input  wire rsp_type  res,
   output      logic     rsp_valid,
   input  wire logic     rsp_stall,
   output      rsp_type  rsp_data,
   output      logic     rsp_ready
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   always_comb begin
      rsp_ready = !valid_ff || !rsp_stall;
      valid_in  = flow.rsp_ready ? (flow.fire && res_valid) : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (flow.rsp_ready) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

FILE: hdl/at_command_frame_parser.sv
// Top level of the AT command frame parser.
// Usage:
//   The request channel carries one beat per received byte or per receive-idle
//   timeout (command = 1). The response channel carries zero or one event per
//   request beat: ok reply, name letter, data byte, frame valid, frame
//   malformed or aborted, with the name and data counts of the frame.
//   A request beat is captured in an input register, evaluated by the parser
//   step logic and placed in the result register, which drives rsp_valid.
//   One beat is taken every cycle while the receiver does not stall; the rate
//   is set by the single parse step between the input and result registers.
//   When the receiver stalls, the result register holds its beat, the input
//   register holds the pending request and req_stall rises once both are
//   full. Beats that produce no event pass through without a response.
//   Reset returns the parser to waiting for 'A' with empty counts and clears
//   both registers' valid flags.
`default_nettype none
module at_command_frame_parser
   import atcp_pkg::*;
#(
   parameter int NAME_MAX    = NAME_MAX_DEFAULT,
   parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   flow_type flow;
   req_type  item;
   logic     res_valid;
   rsp_type  res;
   logic     rsp_ready;

   atcp_req_stage u_req_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .flow      (flow),
      .item      (item)
   );

   atcp_parser #(
      .NAME_MAX    (NAME_MAX),
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .flow      (flow),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   atcp_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .flow      (flow),
      .res_valid (res_valid),
      .res       (res),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .rsp_ready (rsp_ready)
   );

endmodule
`default_nettype wire

FILE: dv/at_command_frame_checker.sv
// Checker for the AT command frame parser: predicts events from request beats and compares.
`default_nettype none
module at_command_frame_checker
   import atcp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending,
   output int           events_checked
);

   phase_type  frame_phase;
   logic [4:0] name_len;
   logic [8:0] payload_len;
   logic [15:0] data_tail;

   rsp_type expected_events[$];
   int      mismatches;
   int      matched;

   initial begin
      mismatches = 0;
      matched    = 0;
   end

   function automatic logic is_letter(logic [7:0] c);
      return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
   endfunction

   function automatic phase_type start_phase(logic [7:0] c);
      return (c == CHAR_UPPER_A || c == CHAR_LOWER_A) ? PH_A : PH_IDLE;
   endfunction

   function automatic void clear_frame();
      name_len    = '0;
      payload_len = '0;
      data_tail   = '0;
   endfunction

   function automatic void note_event(event_type ev, logic [7:0] val);
      rsp_type e;
      e.event_res     = ev;
      e.value         = val;
      e.name_count    = name_len;
      e.payload_count = payload_len;
      expected_events.push_back(e);
   endfunction

   // An abort reports the counts held so far, then the byte may start a new prefix.
   function automatic void abort_frame(logic [7:0] c);
      note_event(EV_ABORT, 8'h00);
      clear_frame();
      frame_phase = start_phase(c);
   endfunction

   function automatic void take_data(logic [7:0] c);
      if (payload_len >= PAYLOAD_MAX_DEFAULT) begin
         abort_frame(c);
      end else begin
         payload_len = payload_len + 9'd1;
         data_tail   = {data_tail[7:0], c};
         note_event(EV_DATA, c);
      end
   endfunction

   function automatic void parse_beat(req_type beat);
      logic [7:0] c;
      c = beat.rx_byte;
      if (beat.command == CMD_TIMEOUT) begin
         if (frame_phase != PH_IDLE) begin
            note_event((payload_len >= MIN_FRAME_BYTES && data_tail == {CHAR_CR, CHAR_LF}) ?
                       EV_VALID : EV_MALFORMED, 8'h00);
            frame_phase = PH_IDLE;
            clear_frame();
         end
      end else begin
         case (frame_phase)
            PH_IDLE: begin
               frame_phase = start_phase(c);
            end
            PH_A: begin
               if (c == CHAR_UPPER_T || c == CHAR_LOWER_T) frame_phase = PH_AT;
               else frame_phase = start_phase(c);
            end
            PH_AT: begin
               if (c == CHAR_PLUS) begin
                  clear_frame();
                  frame_phase = PH_NAME;
               end else if (c == CHAR_CR) begin
                  frame_phase = PH_ATCR;
               end else begin
                  frame_phase = start_phase(c);
               end
            end
            PH_ATCR: begin
               if (c == CHAR_LF) begin
                  clear_frame();
                  note_event(EV_OK, 8'h00);
                  frame_phase = PH_IDLE;
               end else begin
                  frame_phase = start_phase(c);
               end
            end
            PH_NAME: begin
               if (name_len >= NAME_MAX_DEFAULT) begin
                  abort_frame(c);
               end else if (is_letter(c)) begin
                  name_len = name_len + 5'd1;
                  note_event(EV_LETTER, c);
               end else begin
                  // The first byte that is not a letter already belongs to the data.
                  frame_phase = PH_DATA;
                  take_data(c);
               end
            end
            default: begin
               take_data(c);
            end
         endcase
      end
   endfunction

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         frame_phase = PH_IDLE;
         clear_frame();
         expected_events.delete();
      end else begin
         if (req_valid && !req_stall) parse_beat(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               $error("unexpected event beat: event_res %0d value %0d",
                      rsp_data.event_res, rsp_data.value);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               check_field("event_res", want.event_res, rsp_data.event_res);
               check_field("value", want.value, rsp_data.value);
               check_field("name_count", want.name_count, rsp_data.name_count);
               check_field("payload_count", want.payload_count, rsp_data.payload_count);
               matched++;
            end
         end
      end
      fail_count     <= mismatches;
      pending        <= expected_events.size();
      events_checked <= matched;
   end

endmodule
`default_nettype wire

FILE: dv/tb_at_command_frame_parser.sv
// Testbench top for the AT command frame parser: stimulus, flow control and verdict.
`default_nettype none
module tb_at_command_frame_parser;
   import atcp_pkg::*;

   localparam int TARGET_ITEMS = 1500;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 16;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int events_checked;

   int beats_sent    = 0;
   int counted_items = 0;
   int frames_sent   = 0;
   int oversized     = 0;
   int burst_left    = 0;

   int stall_mode    = 0;
   int stall_run     = 0;
   int stall_phase   = 0;
   int idle_cycles;

   always #5 clock = ~clock;

   at_command_frame_parser uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   at_command_frame_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .pending        (pending),
      .events_checked (events_checked)
   );

   // The receiver switches between free flow, random stalls, heavy stalls and a periodic pattern.
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_run  = $urandom_range(8, 64);
      end else begin
         stall_run--;
      end
      stall_phase++;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: rsp_stall <= ($urandom_range(0, 7) != 0);
         default: rsp_stall <= (stall_phase % 3 == 0);
      endcase
   end

   // Holds one beat on the request channel until it is taken; gaps fall between bursts.
   task automatic send_beat(input logic cmd, input logic [7:0] b, input bit counted);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= '{command: cmd, rx_byte: b};
      do @(posedge clock); while (req_stall);
      beats_sent++;
      if (counted) counted_items++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(CMD_BYTE, s[i], 1'b1);
   endtask

   task automatic send_at();
      send_beat(CMD_BYTE, $urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A, 1'b1);
      send_beat(CMD_BYTE, $urandom_range(0, 1) ? CHAR_LOWER_T : CHAR_UPPER_T, 1'b1);
   endtask

   task automatic send_frame(input bit big);
      int         kind;
      int         name_len;
      int         payload_len;
      bit         crlf;
      logic [7:0] c;
      kind = big ? 99 : $urandom_range(0, 99);
      frames_sent++;
      if (kind < 10) begin
         // Line noise, which mostly falls through without a beat in return.
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 4) == 0) send_beat(CMD_TIMEOUT, 8'($urandom), 1'b0);
            else send_beat(CMD_BYTE, 8'($urandom), 1'b0);
         end
      end else if (kind < 25) begin
         send_at();
         send_beat(CMD_BYTE, CHAR_CR, 1'b1);
         if ($urandom_range(0, 3) == 0) send_beat(CMD_BYTE, 8'($urandom), 1'b1);
         else send_beat(CMD_BYTE, CHAR_LF, 1'b1);
      end else if (kind < 35) begin
         // A prefix cut short by a stray byte or by the idle timeout.
         send_beat(CMD_BYTE, $urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A, 1'b1);
         if ($urandom_range(0, 1)) begin
            send_beat(CMD_BYTE, CHAR_UPPER_T, 1'b1);
            if ($urandom_range(0, 1)) send_beat(CMD_BYTE, CHAR_CR, 1'b1);
         end
         if ($urandom_range(0, 1)) send_beat(CMD_TIMEOUT, 8'($urandom), 1'b1);
         else send_beat(CMD_BYTE, 8'($urandom), 1'b1);
      end else begin
         send_at();
         send_beat(CMD_BYTE, CHAR_PLUS, 1'b1);
         if (big) name_len = $urandom_range(1, 4);
         else if ($urandom_range(0, 9) == 0) name_len = $urandom_range(15, 18);
         else name_len = $urandom_range(0, 8);
         repeat (name_len) begin
            c = CHAR_UPPER_A + 8'($urandom_range(0, 25));
            if ($urandom_range(0, 1)) c = c | 8'h20;
            send_beat(CMD_BYTE, c, 1'b1);
         end
         payload_len = big ? $urandom_range(254, 256) : $urandom_range(0, 12);
         crlf = ($urandom_range(0, 2) != 0);
         for (int i = 0; i < payload_len; i++) begin
            c = 8'($urandom);
            if ($urandom_range(0, 7) == 0) c = $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
            // Keep the first data byte from extending the name.
            if (i == 0 && ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
                           (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)))
               c = c ^ 8'h40;
            send_beat(CMD_BYTE, c, 1'b1);
         end
         if (crlf) begin
            send_beat(CMD_BYTE, CHAR_CR, 1'b1);
            send_beat(CMD_BYTE, CHAR_LF, 1'b1);
         end
         if ($urandom_range(0, 9) != 0) send_beat(CMD_TIMEOUT, 8'($urandom), 1'b1);
      end
   endtask

   // Ends the run when neither channel has moved a beat for too long.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("tb_at_command_frame_parser failed");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: letter boundaries, extreme data bytes, prefix mismatches and timeouts.
      send_text("AT+AzZa");
      send_beat(CMD_BYTE, 8'h00, 1'b1);
      send_beat(CMD_BYTE, 8'hFF, 1'b1);
      send_text("\r\n");
      send_beat(CMD_TIMEOUT, 8'hFF, 1'b1);
      send_beat(CMD_TIMEOUT, 8'h00, 1'b1);
      send_text("AAT\rat\r\n");
      send_text("at");
      send_beat(CMD_TIMEOUT, 8'h5A, 1'b1);

      while (counted_items < TARGET_ITEMS) begin
         if (frames_sent % 60 == 30) begin
            oversized++;
            send_frame(1'b1);
         end else begin
            send_frame(1'b0);
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request beats in %0d random frames (%0d with near-full data).",
               beats_sent, frames_sent, oversized);
      $display("Checked %0d event beats against the prediction.", events_checked);
      if (fail_count == 0) begin
         $display("tb_at_command_frame_parser passed");
      end else begin
         $display("tb_at_command_frame_parser failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
